// ===== src/dlee_pkg.sv =====
// Package for the DWARF location expression evaluator.
// Opcodes, parse phases, status codes, config indices and sizes; no dependencies.
package dlee_pkg;

    localparam int REG_COUNT         = 32;
    localparam int MAX_POINTER_BYTES = 8;
    localparam int REG_AW            = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int WORD_BYTES        = 8;

    localparam logic [7:0] OPC_FBREG       = 8'h91;
    localparam logic [7:0] OPC_BREG0       = 8'h70;
    localparam logic [7:0] OPC_BREG31      = 8'h8f;
    localparam logic [7:0] OPC_BREGX       = 8'h92;
    localparam logic [7:0] OPC_REG0        = 8'h50;
    localparam logic [7:0] OPC_REG31       = 8'h6f;
    localparam logic [7:0] OPC_REGX        = 8'h90;
    localparam logic [7:0] OPC_ADDR        = 8'h03;
    localparam logic [7:0] OPC_CONSTU      = 8'h10;
    localparam logic [7:0] OPC_CONSTS      = 8'h11;
    localparam logic [7:0] OPC_STACK_VALUE = 8'h9f;

    localparam logic [6:0] LEB_STEP      = 7'd7;
    localparam logic [6:0] LEB_SHIFT_MAX = 7'd70;
    localparam logic [6:0] WORD_BITS     = 7'd64;

    typedef enum logic [2:0] {
        PH_OPCODE   = 3'd0,
        PH_SLEB_OFS = 3'd1,
        PH_ULEB_REG = 3'd2,
        PH_ADDR     = 3'd3,
        PH_ULEB_VAL = 3'd4,
        PH_SLEB_VAL = 3'd5,
        PH_ERROR    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_RESULT  = 3'd1,
        ST_BAD_OPCODE = 3'd2,
        ST_TRUNC_ADDR = 3'd3,
        ST_BAD_REG    = 3'd4
    } t_status;

    typedef enum logic {
        CFG_BASE_ADDR     = 1'b0,
        CFG_POINTER_BYTES = 1'b1
    } t_cfg_idx;

endpackage

// ===== src/dwarf_location_expr_eval.sv =====
// Top level of the DWARF location expression evaluator.
// Uses dlee_pkg for opcodes, phases and status codes.
//
// channel   dir  handshake                 word
// input     in   i_in_valid / o_in_stall   op, expr_byte, last_byte, reg_index, reg_value
// result    out  o_out_valid / i_out_stall status, is_memory, location_value
// config    in   i_cfg_we (no wait)        cfg_index, cfg_data
//
// One word is taken every cycle unless stalled; each last byte's result is registered.
// The input register feeds the decode, the operand accumulate and a 32-way register
// file read, which together set the cycle. Reset clears the register file and all
// parse state at once. A held result stalls only a last byte; other words flow on.
module dwarf_location_expr_eval (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [7:0]  i_expr_byte,
    input  logic        i_last_byte,
    input  logic [4:0]  i_reg_index,
    input  logic [63:0] i_reg_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_is_memory,
    output logic [63:0] o_location_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int AW = dlee_pkg::REG_AW;

    logic [63:0] r_base_addr;
    logic [3:0]  r_ptr_bytes;

    logic        r_in_valid;
    logic        r_op;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [4:0]  r_ridx;
    logic [63:0] r_rval;

    dlee_pkg::t_phase  r_phase, n_phase;
    logic [7:0]        r_opc, n_opc;
    logic [63:0]       r_acc, n_acc;
    logic [6:0]        r_shift, n_shift;
    logic [AW-1:0]     r_pend, n_pend;
    logic [3:0]        r_cnt, n_cnt;
    logic              r_kind, n_kind;
    logic [63:0]       r_word, n_word;
    logic              r_have, n_have;
    dlee_pkg::t_status r_err, n_err;

    logic [63:0] r_rf [dlee_pkg::REG_COUNT];

    logic        r_out_valid;
    logic [2:0]  r_status;
    logic        r_is_mem;
    logic [63:0] r_loc;

    logic        out_free;
    logic        proc;
    logic        in_accept;
    logic [63:0] leb_acc;
    logic [6:0]  leb_shift;
    logic [63:0] leb_val;
    logic [63:0] addr_acc;
    logic [3:0]  cnt_inc;
    logic [3:0]  ptr_lim;
    logic [7:0]  breg_sub;
    logic [7:0]  reg_sub;
    logic        is_breg;
    logic        is_reg;
    logic [AW-1:0] rd_addr;
    logic [63:0] rd_data;
    dlee_pkg::t_status res_status;
    logic        res_kind;
    logic [63:0] res_word;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && (r_op || !r_last || out_free);
    assign o_in_stall = r_in_valid && !proc;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign ptr_lim = (r_ptr_bytes > 4'(dlee_pkg::MAX_POINTER_BYTES))
                   ? 4'(dlee_pkg::MAX_POINTER_BYTES) : r_ptr_bytes;

    assign leb_acc = (r_shift < dlee_pkg::WORD_BITS)
                   ? (r_acc | ({57'd0, r_byte[6:0]} << r_shift[5:0])) : r_acc;
    assign leb_shift = (r_shift >= dlee_pkg::LEB_SHIFT_MAX - dlee_pkg::LEB_STEP)
                     ? dlee_pkg::LEB_SHIFT_MAX : r_shift + dlee_pkg::LEB_STEP;
    assign leb_val = ((r_phase == dlee_pkg::PH_SLEB_OFS || r_phase == dlee_pkg::PH_SLEB_VAL)
                      && leb_shift < dlee_pkg::WORD_BITS && r_byte[6])
                   ? (leb_acc | ({64{1'b1}} << leb_shift[5:0])) : leb_acc;

    assign addr_acc = (r_cnt < 4'(dlee_pkg::WORD_BYTES))
                    ? (r_acc | ({56'd0, r_byte} << {r_cnt[2:0], 3'b000})) : r_acc;
    assign cnt_inc  = r_cnt + 4'd1;

    assign breg_sub = r_byte - dlee_pkg::OPC_BREG0;
    assign reg_sub  = r_byte - dlee_pkg::OPC_REG0;
    assign is_breg  = r_byte >= dlee_pkg::OPC_BREG0 && r_byte <= dlee_pkg::OPC_BREG31;
    assign is_reg   = r_byte >= dlee_pkg::OPC_REG0 && r_byte <= dlee_pkg::OPC_REG31;

    always_comb begin
        unique case (r_phase)
            dlee_pkg::PH_OPCODE: begin
                if (is_breg) begin
                    rd_addr = breg_sub[AW-1:0];
                end else if (is_reg) begin
                    rd_addr = reg_sub[AW-1:0];
                end else begin
                    rd_addr = '0;
                end
            end
            dlee_pkg::PH_SLEB_OFS: rd_addr = r_pend;
            dlee_pkg::PH_ULEB_REG: rd_addr = leb_acc[AW-1:0];
            default:               rd_addr = '0;
        endcase
    end

    assign rd_data = r_rf[rd_addr];

    // expression byte: next parse state
    always_comb begin
        n_phase = r_phase;
        n_opc   = r_opc;
        n_acc   = r_acc;
        n_shift = r_shift;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        n_word  = r_word;
        n_have  = r_have;
        n_err   = r_err;
        if (r_phase == dlee_pkg::PH_OPCODE) begin
            n_opc   = r_byte;
            n_acc   = '0;
            n_shift = '0;
            n_cnt   = '0;
            if (r_byte == dlee_pkg::OPC_FBREG) begin
                n_phase = dlee_pkg::PH_SLEB_OFS;
                if (r_last) begin
                    n_phase = dlee_pkg::PH_OPCODE;
                    n_kind  = 1'b1;
                    n_word  = r_base_addr;
                    n_have  = 1'b1;
                end
            end else if (is_breg) begin
                if (breg_sub >= 8'(dlee_pkg::REG_COUNT)) begin
                    n_err   = dlee_pkg::ST_BAD_REG;
                    n_phase = dlee_pkg::PH_ERROR;
                end else begin
                    n_pend  = breg_sub[AW-1:0];
                    n_phase = dlee_pkg::PH_SLEB_OFS;
                    if (r_last) begin
                        n_phase = dlee_pkg::PH_OPCODE;
                        n_kind  = 1'b1;
                        n_word  = rd_data;
                        n_have  = 1'b1;
                    end
                end
            end else if (r_byte == dlee_pkg::OPC_BREGX || r_byte == dlee_pkg::OPC_REGX) begin
                n_phase = dlee_pkg::PH_ULEB_REG;
                if (r_last) begin
                    // missing register number reads as register 0
                    n_pend  = '0;
                    n_phase = dlee_pkg::PH_OPCODE;
                    n_kind  = (r_byte == dlee_pkg::OPC_BREGX);
                    n_word  = rd_data;
                    n_have  = 1'b1;
                end
            end else if (is_reg) begin
                if (reg_sub >= 8'(dlee_pkg::REG_COUNT)) begin
                    n_err   = dlee_pkg::ST_BAD_REG;
                    n_phase = dlee_pkg::PH_ERROR;
                end else begin
                    n_kind = 1'b0;
                    n_word = rd_data;
                    n_have = 1'b1;
                end
            end else if (r_byte == dlee_pkg::OPC_ADDR) begin
                n_phase = dlee_pkg::PH_ADDR;
                if (ptr_lim == 4'd0) begin
                    n_phase = dlee_pkg::PH_OPCODE;
                    n_kind  = 1'b1;
                    n_word  = '0;
                    n_have  = 1'b1;
                end else if (r_last) begin
                    n_err   = dlee_pkg::ST_TRUNC_ADDR;
                    n_phase = dlee_pkg::PH_ERROR;
                end
            end else if (r_byte == dlee_pkg::OPC_CONSTU || r_byte == dlee_pkg::OPC_CONSTS) begin
                n_phase = (r_byte == dlee_pkg::OPC_CONSTU) ? dlee_pkg::PH_ULEB_VAL
                                                           : dlee_pkg::PH_SLEB_VAL;
                if (r_last) begin
                    n_phase = dlee_pkg::PH_OPCODE;
                    n_kind  = 1'b0;
                    n_word  = '0;
                    n_have  = 1'b1;
                end
            end else if (r_byte == dlee_pkg::OPC_STACK_VALUE) begin
                n_have = 1'b1;
            end else begin
                n_err   = dlee_pkg::ST_BAD_OPCODE;
                n_phase = dlee_pkg::PH_ERROR;
            end
        end else if (r_phase == dlee_pkg::PH_ADDR) begin
            n_acc = addr_acc;
            n_cnt = cnt_inc;
            if (cnt_inc >= ptr_lim) begin
                n_phase = dlee_pkg::PH_OPCODE;
                n_kind  = 1'b1;
                n_word  = addr_acc;
                n_have  = 1'b1;
            end else if (r_last) begin
                n_err   = dlee_pkg::ST_TRUNC_ADDR;
                n_phase = dlee_pkg::PH_ERROR;
            end
        end else if (r_phase != dlee_pkg::PH_ERROR) begin
            n_acc   = leb_acc;
            n_shift = leb_shift;
            if (!r_byte[7] || r_last) begin
                unique case (r_phase)
                    dlee_pkg::PH_SLEB_OFS: begin
                        n_phase = dlee_pkg::PH_OPCODE;
                        n_kind  = 1'b1;
                        n_word  = ((r_opc == dlee_pkg::OPC_FBREG) ? r_base_addr : rd_data)
                                + leb_val;
                        n_have  = 1'b1;
                    end
                    dlee_pkg::PH_ULEB_REG: begin
                        if (leb_acc >= 64'(dlee_pkg::REG_COUNT)) begin
                            n_err   = dlee_pkg::ST_BAD_REG;
                            n_phase = dlee_pkg::PH_ERROR;
                        end else begin
                            n_pend = leb_acc[AW-1:0];
                            if (r_opc == dlee_pkg::OPC_REGX || r_last) begin
                                n_phase = dlee_pkg::PH_OPCODE;
                                n_kind  = (r_opc != dlee_pkg::OPC_REGX);
                                n_word  = rd_data;
                                n_have  = 1'b1;
                            end else begin
                                n_phase = dlee_pkg::PH_SLEB_OFS;
                                n_acc   = '0;
                                n_shift = '0;
                                n_cnt   = '0;
                            end
                        end
                    end
                    default: begin
                        n_phase = dlee_pkg::PH_OPCODE;
                        n_kind  = 1'b0;
                        n_word  = leb_val;
                        n_have  = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (n_err != dlee_pkg::ST_OK) begin
            res_status = n_err;
            res_kind   = 1'b0;
            res_word   = '0;
        end else if (!n_have) begin
            res_status = dlee_pkg::ST_NO_RESULT;
            res_kind   = 1'b0;
            res_word   = '0;
        end else begin
            res_status = dlee_pkg::ST_OK;
            res_kind   = n_kind;
            res_word   = n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr <= '0;
            r_ptr_bytes <= 4'(dlee_pkg::MAX_POINTER_BYTES);
        end else if (i_cfg_we) begin
            unique case (dlee_pkg::t_cfg_idx'(i_cfg_index))
                dlee_pkg::CFG_BASE_ADDR:     r_base_addr <= i_cfg_data;
                dlee_pkg::CFG_POINTER_BYTES: r_ptr_bytes <= i_cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_op;
            r_byte <= i_expr_byte;
            r_last <= i_last_byte;
            r_ridx <= i_reg_index;
            r_rval <= i_reg_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dlee_pkg::PH_OPCODE;
            r_opc   <= '0;
            r_acc   <= '0;
            r_shift <= '0;
            r_pend  <= '0;
            r_cnt   <= '0;
            r_kind  <= 1'b0;
            r_word  <= '0;
            r_have  <= 1'b0;
            r_err   <= dlee_pkg::ST_OK;
            for (int i = 0; i < dlee_pkg::REG_COUNT; i++) begin
                r_rf[i] <= '0;
            end
        end else if (proc) begin
            if (r_op) begin
                if ({1'b0, r_ridx} < 6'(dlee_pkg::REG_COUNT)) begin
                    r_rf[r_ridx[AW-1:0]] <= r_rval;
                end
            end else if (r_last) begin
                r_phase <= dlee_pkg::PH_OPCODE;
                r_opc   <= '0;
                r_acc   <= '0;
                r_shift <= '0;
                r_pend  <= '0;
                r_cnt   <= '0;
                r_kind  <= 1'b0;
                r_word  <= '0;
                r_have  <= 1'b0;
                r_err   <= dlee_pkg::ST_OK;
            end else begin
                r_phase <= n_phase;
                r_opc   <= n_opc;
                r_acc   <= n_acc;
                r_shift <= n_shift;
                r_pend  <= n_pend;
                r_cnt   <= n_cnt;
                r_kind  <= n_kind;
                r_word  <= n_word;
                r_have  <= n_have;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && !r_op && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && !r_op && r_last) begin
            r_status <= res_status;
            r_is_mem <= res_kind;
            r_loc    <= res_word;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_is_memory      = r_is_mem;
    assign o_location_value = r_loc;

endmodule

// ===== src/dlee_checker.sv =====
// Port-level checks for the DWARF location expression evaluator, bound to its top.
// Uses dlee_pkg for status codes.
module dlee_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic        o_is_memory,
    input logic [63:0] o_location_value
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_location_value) && $stable(o_is_memory))
        else $error("stalled result word changed");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != dlee_pkg::ST_OK |-> !o_is_memory && o_location_value == '0)
        else $error("error result carries a value");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= dlee_pkg::ST_BAD_REG)
        else $error("status code out of range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind dwarf_location_expr_eval dlee_checker u_dlee_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_is_memory      (o_is_memory),
    .o_location_value (o_location_value)
);
